// ===== rtl/stq_pkg.sv =====
// Package for the sorted timer queue: sizes, request codes and the command word type.
// Used by the front end, the back end and the top level; it depends on nothing.
package stq_pkg;
   localparam int N_TIMERS = 16;
   localparam int IDX_W    = 4;
   localparam int CNT_W    = 5;
   localparam int TIME_W   = 64;

   localparam logic [1:0] OP_PLAN   = 2'd0;
   localparam logic [1:0] OP_UNPLAN = 2'd1;
   localparam logic [1:0] OP_TICK   = 2'd2;
   localparam logic [1:0] OP_QUERY  = 2'd3;

   typedef struct packed {
      logic [1:0]        op;
      logic [IDX_W-1:0]  id;
      logic              id_ok;
      logic [TIME_W-1:0] start;
      logic [TIME_W-1:0] interval;
      logic [TIME_W-1:0] now;
   } cmd_type;
endpackage

// ===== rtl/stq_front.sv =====
// Front end of the sorted timer queue: accepts request words, decodes them and holds
// them in a two-entry queue for the back end. Depends on stq_pkg.
module stq_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [1:0]       req_tuser,
   input  logic [199:0]     req_tdata,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output stq_pkg::cmd_type cmd
);
   import stq_pkg::*;

   cmd_type    buf_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    dec;
   logic       push, pop;

   always_comb begin
      dec.op       = req_tuser;
      dec.id       = req_tdata[3:0];
      dec.id_ok    = {1'b0, req_tdata[3:0]} < CNT_W'(N_TIMERS);
      dec.start    = req_tdata[67:4];
      dec.interval = req_tdata[131:68];
      dec.now      = req_tdata[195:132];
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign cmd_valid  = (cnt_ff != 2'd0);
   assign cmd        = buf_ff[rptr_ff];
   assign push       = req_tvalid && req_tready;
   assign pop        = cmd_valid && cmd_ready;
   assign wptr_in    = push ? ~wptr_ff : wptr_ff;
   assign rptr_in    = pop ? ~rptr_ff : rptr_ff;
   assign cnt_in     = cnt_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wptr_ff] <= dec;
      end
   end
endmodule

// ===== rtl/stq_back.sv =====
// Back end of the sorted timer queue: keeps the deadline-ordered list and runs each
// command step by step, emitting expiry and status words. Depends on stq_pkg.
module stq_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  stq_pkg::cmd_type cmd,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic             rsp_tuser,
   output logic [15:0]      rsp_tdata,
   output logic             rsp_tlast
);
   import stq_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_FIND   = 3'd1;
   localparam logic [2:0] S_WRITE  = 3'd2;
   localparam logic [2:0] S_ISCAN  = 3'd3;
   localparam logic [2:0] S_TSCAN  = 3'd4;
   localparam logic [2:0] S_EMIT   = 3'd5;
   localparam logic [2:0] S_SHIFT  = 3'd6;
   localparam logic [2:0] S_STATUS = 3'd7;

   logic [2:0]        state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [CNT_W-1:0]  idx_ff, idx_in, nf_ff, nf_in, cnt_ff, cnt_in, len_ff, len_in;
   logic              hit_ff, hit_in, plan_ff, plan_in;
   logic [TIME_W-1:0] mine_ff, mine_in;
   logic [IDX_W-1:0]  order_ff [N_TIMERS];
   logic [IDX_W-1:0]  order_in [N_TIMERS];
   logic              linked_ff [N_TIMERS];
   logic              linked_in [N_TIMERS];
   logic [TIME_W-1:0] start_ff [N_TIMERS];
   logic [TIME_W-1:0] ival_ff [N_TIMERS];
   logic [TIME_W-1:0] dl_ff [N_TIMERS];
   logic              wr;
   logic [IDX_W-1:0]  cur;
   logic [TIME_W-1:0] ins_diff, now_diff;
   logic              expired, at_end, id_linked;
   logic [CNT_W:0]    src;

   assign cur       = order_ff[idx_ff[IDX_W-1:0]];
   assign ins_diff  = mine_ff - dl_ff[cur];
   assign now_diff  = cmd_ff.now - start_ff[cur];
   assign expired   = $signed(now_diff) >= $signed(ival_ff[cur]);
   assign at_end    = (idx_ff == len_ff);
   assign id_linked = cmd_ff.id_ok && linked_ff[cmd_ff.id];

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      idx_in    = idx_ff;
      nf_in     = nf_ff;
      cnt_in    = cnt_ff;
      len_in    = len_ff;
      hit_in    = hit_ff;
      plan_in   = plan_ff;
      mine_in   = mine_ff;
      order_in  = order_ff;
      linked_in = linked_ff;
      wr        = 1'b0;
      cmd_ready = 1'b0;
      src       = '0;
      case (state_ff)
         S_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cmd_in = cmd;
               idx_in = '0;
               hit_in = 1'b0;
               case (cmd.op)
                  OP_PLAN: begin
                     if (!cmd.id_ok) begin
                        state_in = S_STATUS;
                     end else if (linked_ff[cmd.id]) begin
                        state_in = S_FIND;
                     end else begin
                        state_in = S_WRITE;
                     end
                  end
                  OP_UNPLAN: begin
                     state_in = (cmd.id_ok && linked_ff[cmd.id]) ? S_FIND : S_STATUS;
                  end
                  OP_TICK: state_in = S_TSCAN;
                  default: state_in = S_STATUS;
               endcase
            end
         end
         S_FIND: begin
            if (cur == cmd_ff.id) begin
               for (int j = 0; j < N_TIMERS - 1; j++) begin
                  if (CNT_W'(j) >= idx_ff) begin
                     order_in[j] = order_ff[j+1];
                  end
               end
               len_in = len_ff - 1'b1;
               linked_in[cmd_ff.id] = 1'b0;
               state_in = (cmd_ff.op == OP_PLAN) ? S_WRITE : S_STATUS;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_WRITE: begin
            wr       = 1'b1;
            mine_in  = cmd_ff.start + cmd_ff.interval;
            idx_in   = '0;
            state_in = (len_ff >= CNT_W'(N_TIMERS)) ? S_STATUS : S_ISCAN;
         end
         S_ISCAN: begin
            if (at_end || ins_diff[TIME_W-1]) begin
               for (int j = 1; j < N_TIMERS; j++) begin
                  if (CNT_W'(j) > idx_ff) begin
                     order_in[j] = order_ff[j-1];
                  end
               end
               order_in[idx_ff[IDX_W-1:0]] = cmd_ff.id;
               len_in = len_ff + 1'b1;
               linked_in[cmd_ff.id] = 1'b1;
               state_in = S_STATUS;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_TSCAN: begin
            if (at_end || !expired) begin
               nf_in    = idx_ff;
               cnt_in   = len_ff - idx_ff;
               plan_in  = id_linked && !hit_ff;
               idx_in   = '0;
               state_in = (idx_ff == '0) ? S_STATUS : S_EMIT;
            end else begin
               if (cur == cmd_ff.id) begin
                  hit_in = 1'b1;
               end
               idx_in = idx_ff + 1'b1;
            end
         end
         S_EMIT: begin
            if (rsp_tready) begin
               linked_in[cur] = 1'b0;
               idx_in = idx_ff + 1'b1;
               if (idx_ff + 1'b1 == nf_ff) begin
                  state_in = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            for (int j = 0; j < N_TIMERS; j++) begin
               src = (CNT_W+1)'(j) + {1'b0, nf_ff};
               if (src < (CNT_W+1)'(N_TIMERS)) begin
                  order_in[j] = order_ff[src[IDX_W-1:0]];
               end
            end
            len_in   = len_ff - nf_ff;
            state_in = S_STATUS;
         end
         S_STATUS: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         len_ff   <= '0;
         for (int j = 0; j < N_TIMERS; j++) begin
            linked_ff[j] <= 1'b0;
         end
      end else begin
         state_ff  <= state_in;
         len_ff    <= len_in;
         linked_ff <= linked_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      idx_ff   <= idx_in;
      nf_ff    <= nf_in;
      cnt_ff   <= cnt_in;
      hit_ff   <= hit_in;
      plan_ff  <= plan_in;
      mine_ff  <= mine_in;
      order_ff <= order_in;
      if (wr) begin
         start_ff[cmd_ff.id] <= cmd_ff.start;
         ival_ff[cmd_ff.id]  <= cmd_ff.interval;
         dl_ff[cmd_ff.id]    <= mine_in;
      end
   end

   assign rsp_tvalid = (state_ff == S_EMIT) || (state_ff == S_STATUS);
   assign rsp_tuser  = (state_ff == S_EMIT);
   assign rsp_tlast  = (state_ff == S_STATUS);
   always_comb begin
      rsp_tdata = '0;
      if (state_ff == S_EMIT) begin
         rsp_tdata[3:0] = cur;
         rsp_tdata[4]   = plan_ff;
         rsp_tdata[9:5] = cnt_ff;
      end else begin
         rsp_tdata[4]   = id_linked;
         rsp_tdata[9:5] = len_ff;
      end
   end
endmodule

// ===== rtl/sorted_timer_queue_top.sv =====
// Top level of the sorted timer queue: joins the decoding front end and the list engine.
// Depends on stq_pkg, stq_front and stq_back.
//
//   Channel  Direction  Contents
//   req_*    in         request word: kind in tuser, slot and times in tdata
//   rsp_*    out        expiry or status word, tlast on the final word of a request
//
// In the back end, a query and an unplan of an idle slot go straight to the status word,
// and an unplan of a queued slot first scans the list for it. A plan scans the list one
// entry a cycle to find the old place and again for the new one. A tick scans the expired
// timers and, when any fire, sends one expiry word a cycle while the result side does not
// stall. Reset is synchronous and empties the queue at once. A two-entry request queue
// keeps accepting requests until it is full while the result side stalls.
module sorted_timer_queue_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,  // req_type
   input  logic [199:0] req_tdata,  // timer_id, start_time, interval_ticks, now_time
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic         rsp_tuser,  // result_kind
   output logic [15:0]  rsp_tdata,  // fired_id, is_planned, queued_count
   output logic         rsp_tlast
);
   import stq_pkg::*;

   cmd_type cmd;
   logic    cmd_valid, cmd_ready;

   stq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd)
   );

   stq_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd_ready  (cmd_ready),
      .cmd        (cmd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );
endmodule

// ===== rtl/stq_checker.sv =====
// Port checker for the sorted timer queue, bound to the top level.
// Depends on sorted_timer_queue_top's ports only.
module stq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic        rsp_tuser,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid) else $error("result word dropped");
   a_fire_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> !rsp_tlast) else $error("expiry word marked last");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast && rsp_tdata[3:0] == 4'd0)
      else $error("malformed status word");
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[9:5] <= 5'd16) else $error("queued count too large");
endmodule

bind sorted_timer_queue_top stq_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
